>>> design/fat_pkg.sv
package fat_pkg;

  // Field widths fixed by the interface
  localparam int KIND_W    = 3;
  localparam int TIME_W    = 32;
  localparam int SLOT_W    = 4;
  localparam int CNT_W     = 5;
  localparam int IDX_OUT_W = 4;

  // Defaults for the top level parameters
  localparam int MAX_FRAMES_DEF  = 16;
  localparam int MAX_ADVANCE_DEF = 16;

  // Command codes
  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PLAY  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PAUSE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STOP  = 3'd4;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } fat_state_t;

endpackage

>>> design/fat_dur_mem.sv
module fat_dur_mem #(
  parameter int DEPTH = fat_pkg::MAX_FRAMES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [fat_pkg::TIME_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [fat_pkg::TIME_W-1:0] rd_data
);
  import fat_pkg::*;

  logic [TIME_W-1:0] mem [DEPTH];
  logic [TIME_W-1:0] rd_data_r;

  // Duration table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/frame_animation_timer_top.sv
// A tick while playing passes from S_IDLE through S_WALK, which advances k frames
// (0 to MAX_ADVANCE), one duration table read and subtract per frame step, to S_DONE;
// every other item passes from S_IDLE straight to S_DONE, which registers the result.
// One item at a time: a new item is taken only in S_IDLE, after the result is handed off.
// Reset clears index, elapsed time, playback flags, frame count and out_valid; the
// result payload and duration table are not cleared; the table holds garbage until loaded.
module frame_animation_timer_top #(
  parameter int MAX_FRAMES  = fat_pkg::MAX_FRAMES_DEF,
  parameter int MAX_ADVANCE = fat_pkg::MAX_ADVANCE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fat_pkg::CNT_W-1:0]     cfg_frame_count,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fat_pkg::KIND_W-1:0]    in_kind,
  input  logic [fat_pkg::TIME_W-1:0]    in_delta_time,
  input  logic [fat_pkg::SLOT_W-1:0]    in_frame_slot,
  input  logic [fat_pkg::TIME_W-1:0]    in_frame_duration_in,
  input  logic                          in_loop_mode,
  // results
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fat_pkg::IDX_OUT_W-1:0] out_frame_index,
  output logic                          out_is_playing,
  output logic                          out_is_finished
);
  import fat_pkg::*;

  localparam int AW   = $clog2(MAX_FRAMES);
  localparam int STPW = $clog2(MAX_ADVANCE + 1);

  fat_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   index_r, index_nxt;
  logic [TIME_W-1:0]  elapsed_r, elapsed_nxt;
  logic               running_r, running_nxt;
  logic               wrap_r, wrap_nxt;
  logic [STPW-1:0]    steps_r, steps_nxt;
  logic [CNT_W-1:0]   frame_count_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_OUT_W-1:0] out_index_r, out_index_nxt;
  logic                 out_play_r, out_play_nxt;
  logic                 out_fin_r, out_fin_nxt;

  logic               in_xfer;
  logic [CNT_W-1:0]   n_eff;
  logic [TIME_W:0]    sum;
  logic [TIME_W-1:0]  dur;
  logic [CNT_W-1:0]   idx_inc;
  logic               wr_en;
  logic               finished;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;

  // Effective frame count, saturated at the table depth
  assign n_eff = (32'(frame_count_r) > MAX_FRAMES) ? CNT_W'(MAX_FRAMES) : frame_count_r;

  assign sum     = {1'b0, elapsed_r} + {1'b0, in_delta_time};
  assign idx_inc = index_r + 1'b1;
  assign wr_en   = in_xfer && (in_kind == KIND_LOAD) && (32'(in_frame_slot) < MAX_FRAMES);

  // Status from the updated state
  assign finished = !running_r &&
                    ((n_eff == '0) || ({1'b0, index_r} + 1'b1 >= {1'b0, n_eff}));

  fat_dur_mem #(
    .DEPTH (MAX_FRAMES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_frame_slot)),
    .wr_data (in_frame_duration_in),
    .rd_addr (AW'(index_nxt)),
    .rd_data (dur)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      frame_count_r <= cfg_frame_count;
    end
  end

  // Control and timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      index_r     <= '0;
      elapsed_r   <= '0;
      running_r   <= 1'b0;
      wrap_r      <= 1'b0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      index_r     <= index_nxt;
      elapsed_r   <= elapsed_nxt;
      running_r   <= running_nxt;
      wrap_r      <= wrap_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_index_r <= out_index_nxt;
    out_play_r  <= out_play_nxt;
    out_fin_r   <= out_fin_nxt;
  end

  // Sequencer: command decode, frame walk, result hand-off
  always_comb begin
    state_nxt     = state_r;
    index_nxt     = index_r;
    elapsed_nxt   = elapsed_r;
    running_nxt   = running_r;
    wrap_nxt      = wrap_r;
    steps_nxt     = steps_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_index_nxt = out_index_r;
    out_play_nxt  = out_play_r;
    out_fin_nxt   = out_fin_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_DONE;
          case (in_kind)
            KIND_TICK: begin
              if (running_r && (n_eff != '0)) begin
                elapsed_nxt = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                // index left beyond a shrunk count
                if (index_r >= n_eff) begin
                  if (wrap_r) begin
                    index_nxt = '0;
                  end else begin
                    index_nxt   = n_eff - 1'b1;
                    running_nxt = 1'b0;
                  end
                end
                steps_nxt = '0;
                state_nxt = S_WALK;
              end
            end
            KIND_LOAD: begin
              index_nxt   = '0;
              elapsed_nxt = '0;
              running_nxt = 1'b0;
            end
            KIND_PLAY: begin
              wrap_nxt    = in_loop_mode;
              running_nxt = (n_eff != '0);
            end
            KIND_PAUSE: begin
              running_nxt = 1'b0;
            end
            KIND_STOP: begin
              running_nxt = 1'b0;
              index_nxt   = '0;
              elapsed_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // dur holds the duration of frame index_r
      S_WALK: begin
        if (!running_r || (32'(steps_r) >= MAX_ADVANCE) || (elapsed_r < dur)) begin
          state_nxt = S_DONE;
        end else begin
          elapsed_nxt = elapsed_r - dur;
          steps_nxt   = steps_r + 1'b1;
          if (idx_inc >= n_eff) begin
            if (wrap_r) begin
              index_nxt = '0;
            end else begin
              index_nxt   = n_eff - 1'b1;
              running_nxt = 1'b0;
            end
          end else begin
            index_nxt = idx_inc;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = IDX_OUT_W'(index_r);
          out_play_nxt  = running_r;
          out_fin_nxt   = finished;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_frame_index = out_index_r;
  assign out_is_playing  = out_play_r;
  assign out_is_finished = out_fin_r;

`ifndef SYNTHESIS
  // Walk never takes more frame steps than allowed
  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> 32'(steps_r) <= MAX_ADVANCE)
    else $error("frame walk exceeded step limit");

  // Walk ends once playback has stopped
  a_walk_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && !running_r) |=> state_r == S_DONE)
    else $error("frame walk continued after playback stopped");

  // After a walk the index lies within the sequence
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && state_nxt == S_DONE) |-> index_r < n_eff)
    else $error("frame index beyond count after walk");

  // Result held in S_DONE while the output is stalled
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> state_r == S_DONE)
    else $error("result dropped while output stalled");
`endif

endmodule
